FILE: rtl/core/hwrld_pkg.sv
`default_nettype none
package hwrld_pkg;
  localparam int WindowSize = 1024;
  localparam int AddrBits = 10;
  localparam int SampleBits = 16;
  localparam int WeightBits = 24;
  localparam int AccBits = 66;
  localparam logic [10:0] IntervalReset = 11'd512;
  localparam logic [AddrBits-1:0] WindowLast = 10'd1023;
  localparam logic [25:0] DbPerOctaveQ24 = 26'd50504453;
  localparam logic [14:0] FullScaleLevel = 15'd25600;
  localparam int CfgAddrBits = 3;
  localparam logic [CfgAddrBits-1:0] RegWindowInterval = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_PRIME, ST_MAC, ST_DRAIN, ST_LOG, ST_SCALE, ST_OUT
  } state_t;

  // Truncated Q16 log2 of a nonzero 32-bit value, by repeated squaring.
  function automatic logic [22:0] log2_q16_of(input logic [31:0] v);
    int e;
    logic [63:0] m;
    logic [15:0] frac;
    e = 0;
    for (int b = 0; b < 32; b++) if (v[b]) e = b;
    m = 64'(v) << (31 - e);
    frac = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = {frac[14:0], 1'b0};
      if (m >= (64'd2 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return 23'(e * 65536) + 23'(frac);
  endfunction

  // Q16 log2(1023) plus 2*SampleBits+20.
  localparam logic [22:0] LogOffsetQ16 = 23'd3407872 + log2_q16_of(32'd1023);

  // Q30 cosine of a phase in Q32 turns, octant reduced Taylor series.
  function automatic logic signed [31:0] cosine_q30(input logic [32:0] phase);
    logic [32:0] p;
    logic neg, sn;
    logic [63:0] x, x2, t, r;
    p = phase; neg = 1'b0; sn = 1'b0;
    if (p > 33'h80000000) p = 33'h100000000 - p;
    if (p > 33'h40000000) begin p = 33'h80000000 - p; neg = 1'b1; end
    if (p > 33'h20000000) begin p = 33'h40000000 - p; sn = 1'b1; end
    x = ({31'd0, p} * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    if (sn) begin
      t = (64'd1 << 30) - x2 / 64'd72;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      r = (x * t) >> 30;
    end else begin
      t = (64'd1 << 30) - x2 / 64'd90;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd56;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd30;
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd12;
      r = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd2;
    end
    return neg ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  function automatic logic [WeightBits-1:0] hann_weight(input logic [AddrBits-1:0] k);
    logic [32:0] ph;
    logic signed [32:0] d;
    ph = 33'((64'(k) << 32) / 64'd1023);
    d = 33'sh40000000 - 33'(cosine_q30(ph));
    return WeightBits'((d + 33'sd128) >>> 8);
  endfunction

  typedef logic [WeightBits-1:0] wtab_t [WindowSize];
  function automatic wtab_t build_weights();
    wtab_t w;
    for (int i = 0; i < WindowSize; i++) w[i] = hann_weight(AddrBits'(i));
    return w;
  endfunction
  localparam wtab_t WeightTable = build_weights();
endpackage
`default_nettype wire

FILE: rtl/core/hwrld_stream_if.sv
`default_nettype none
interface hwrld_stream_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hwrld_ram.sv
`default_nettype none
module hwrld_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/hann_windowed_rms_level_db_unit.sv
`default_nettype none
// Flow: a sample closing an interval gives its level after a read of every
// ring entry, a multiply pipeline drain, the log2 squaring steps, a scale
// step and the output register load; an all-zero window skips squaring and scale.
// Throughput: other samples are taken one per cycle; a closing sample holds
// the input off until its level moves into the output register.
// Reset: every ring RAM entry is cleared with in_ready low.
module hann_windowed_rms_level_db_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  hwrld_stream_if.sink in_s,
  hwrld_stream_if.source out_s,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [hwrld_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int AB = hwrld_pkg::AddrBits;

  hwrld_pkg::state_t state_r, state_nxt;
  logic [10:0] interval_r;
  logic [10:0] count_r, count_nxt;
  logic [AB-1:0] wpos_r, wpos_nxt;
  logic [AB:0] k_r, k_nxt;        // MAC read index counter
  logic [AB-1:0] rd_r, rd_nxt;    // ring read address
  logic [AB-1:0] wk_r;            // weight index of the data now on the RAM output
  logic mac_v_r;
  logic [hwrld_pkg::AccBits-1:0] acc_r, acc_nxt;
  logic [31:0] m_r, m_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [6:0] exp_r, exp_nxt;
  logic [4:0] step_r, step_nxt;
  logic [14:0] level_r, level_nxt;
  logic [14:0] out_lvl_r, out_lvl_nxt;
  logic out_v_r, out_v_nxt;

  logic ram_we;
  logic [AB-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;

  hwrld_ram #(.Width(16), .Depth(hwrld_pkg::WindowSize)) u_ring (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == hwrld_pkg::RegWindowInterval) ? {21'd0, interval_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) interval_r <= hwrld_pkg::IntervalReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr == hwrld_pkg::RegWindowInterval)
      interval_r <= cfg_pwdata[10:0];
  end

  // Pipeline: square and weight registered, their product then accumulated.
  logic signed [31:0] sq_r;
  logic [hwrld_pkg::WeightBits-1:0] w_r;
  logic prod_v_r;
  logic [55:0] prod;
  assign prod = 56'(sq_r) * 56'(w_r);

  logic [31:0] msb_src;
  logic [63:0] msq;
  assign msq = 64'(m_r) * 64'(m_r);

  // Exponent search over the 66-bit accumulator uses a priority encoder on the
  // registered accumulator (66 bits, single pass); its result is loaded as
  // ST_DRAIN hands over to ST_LOG.
  logic [6:0] top;
  always_comb begin
    top = 7'd0;
    for (int i = 0; i < hwrld_pkg::AccBits; i++) if (acc_r[i]) top = 7'(i);
  end
  logic [hwrld_pkg::AccBits+31:0] shifted;
  assign shifted = ({32'd0, acc_r} << 31) >> top;
  assign msb_src = shifted[31:0];

  logic signed [24:0] lvl;
  logic signed [55:0] total;
  logic [23:0] rounded;
  assign lvl = $signed({2'b0, exp_r, frac_r}) - $signed({2'b0, hwrld_pkg::LogOffsetQ16});
  assign total = 56'(lvl) * $signed({30'd0, hwrld_pkg::DbPerOctaveQ24})
                 + (56'sd25600 <<< 32);
  assign rounded = 24'((total + 56'sh80000000) >>> 32);

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; wpos_nxt = wpos_r;
    k_nxt = k_r; rd_nxt = rd_r; acc_nxt = acc_r; m_nxt = m_r;
    frac_nxt = frac_r; exp_nxt = exp_r; step_nxt = step_r;
    level_nxt = level_r; out_lvl_nxt = out_lvl_r; out_v_nxt = out_v_r;
    in_s.ready = 1'b0;
    ram_we = 1'b0; ram_waddr = wpos_r; ram_wdata = in_s.data; ram_raddr = rd_r;
    if (out_v_r && out_s.ready) out_v_nxt = 1'b0;
    if (prod_v_r) acc_nxt = acc_r + hwrld_pkg::AccBits'(prod);
    case (state_r)
      hwrld_pkg::ST_CLEAR: begin
        ram_we = 1'b1; ram_waddr = wpos_r; ram_wdata = 16'd0;
        wpos_nxt = wpos_r + 1'b1;
        if (wpos_r == hwrld_pkg::WindowLast) state_nxt = hwrld_pkg::ST_IDLE;
      end
      hwrld_pkg::ST_IDLE: begin
        // The output register holds any waiting level, so samples keep flowing.
        in_s.ready = 1'b1;
        if (in_s.valid && in_s.ready) begin
          ram_we = 1'b1;
          wpos_nxt = wpos_r + 1'b1;
          if (count_r + 11'd1 >= interval_r) begin
            count_nxt = 11'd0;
            rd_nxt = wpos_r + 1'b1;
            k_nxt = '0; acc_nxt = '0;
            state_nxt = hwrld_pkg::ST_MAC;
          end else count_nxt = count_r + 11'd1;
        end
      end
      hwrld_pkg::ST_MAC: begin
        ram_raddr = rd_r;
        rd_nxt = rd_r + 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == (AB+1)'(hwrld_pkg::WindowSize - 1)) state_nxt = hwrld_pkg::ST_DRAIN;
      end
      hwrld_pkg::ST_DRAIN: begin
        if (!mac_v_r && !prod_v_r) begin
          step_nxt = '0; frac_nxt = '0;
          state_nxt = hwrld_pkg::ST_LOG;
          exp_nxt = top; m_nxt = msb_src;
        end
      end
      hwrld_pkg::ST_LOG: begin
        if (acc_r == '0) begin
          level_nxt = '0; state_nxt = hwrld_pkg::ST_OUT;
        end else begin
          if (msq[63]) begin
            m_nxt = msq[63:32]; frac_nxt = {frac_r[14:0], 1'b1};
          end else begin
            m_nxt = msq[62:31]; frac_nxt = {frac_r[14:0], 1'b0};
          end
          step_nxt = step_r + 1'b1;
          if (step_r == 5'd15) state_nxt = hwrld_pkg::ST_SCALE;
        end
      end
      hwrld_pkg::ST_SCALE: begin
        if (total <= 0) level_nxt = '0;
        else if (rounded > 24'(hwrld_pkg::FullScaleLevel)) level_nxt = hwrld_pkg::FullScaleLevel;
        else level_nxt = rounded[14:0];
        state_nxt = hwrld_pkg::ST_OUT;
      end
      hwrld_pkg::ST_OUT: begin
        // Waits here while an earlier level still sits in the output register.
        if (!out_v_r || out_s.ready) begin
          out_lvl_nxt = level_r;
          out_v_nxt = 1'b1; state_nxt = hwrld_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hwrld_pkg::ST_IDLE;
    endcase
  end

  assign out_s.valid = out_v_r;
  assign out_s.data = out_lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hwrld_pkg::ST_CLEAR;
      count_r <= '0; wpos_r <= '0; out_v_r <= 1'b0;
      mac_v_r <= 1'b0; prod_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; wpos_r <= wpos_nxt;
      out_v_r <= out_v_nxt;
      mac_v_r <= (state_r == hwrld_pkg::ST_MAC);
      prod_v_r <= mac_v_r;
    end
    k_r <= k_nxt; rd_r <= rd_nxt; acc_r <= acc_nxt; m_r <= m_nxt;
    frac_r <= frac_nxt; exp_r <= exp_nxt; step_r <= step_nxt; level_r <= level_nxt;
    out_lvl_r <= out_lvl_nxt;
    wk_r <= k_r[AB-1:0];
    sq_r <= $signed(ram_rdata) * $signed(ram_rdata);
    w_r <= hwrld_pkg::WeightTable[wk_r];
  end
endmodule
`default_nettype wire
